### rtl/cidr_pkg.sv
// cidr_pkg: shared constants, types and helpers for the can id demux ring buffers
// used by cidr_ctrl, cidr_dp, the top level and the checker
`timescale 1ns / 1ps

package cidr_pkg;

  localparam int RING_DEPTH  = 256;
  localparam int SLOT_COUNT  = 2;
  localparam int REG_COUNT   = 2;
  localparam int STORE_DEPTH = SLOT_COUNT * RING_DEPTH;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = 1;
  localparam int ID_W        = 29;
  localparam int CNT_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 8;
  localparam int BIDX_W      = $clog2(MAX_BYTES);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_ID = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } cidr_status_t;

  // controller to datapath
  typedef struct packed {
    logic         load;
    logic         wr_byte;
    logic         rd_issue;
    logic         rd_take;
    logic         res_load;
    cidr_status_t res_status;
  } cidr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic matched;
    logic fits;
    logic zero_count;
    logic empty;
    logic last_byte;
  } cidr_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(s) * ADDR_W'(RING_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

### rtl/can_id_demux_ring_buffers.sv
// can_id_demux_ring_buffers: top level, can receive id filter with one byte ring per slot
// depends on cidr_pkg, cidr_ctrl, cidr_dp (and cidr_ram through cidr_dp)
`timescale 1ns / 1ps

// A beat is taken at the rising edge where start is high and busy is low. With in_action low
// the beat is a received frame: its id is compared with the two slot id registers (slot 0 wins
// when both match), and the frame is refused as unknown, refused as full when its bytes do not
// all fit into the slot's ring (each ring holds at most RING_DEPTH-1 bytes), or appended whole.
// A byte count above eight is taken as eight. With in_action high the beat reads the oldest
// byte of ring in_read_slot, or reports the ring empty. Every beat gives exactly one result,
// shown for one cycle with out_strobe high; the receiver cannot stall it, so it must take it
// then. A receive is checked after accept, then its n bytes (the clamped count) are written
// one per cycle through the single write port of the byte store before the result is loaded;
// a refused or zero byte frame is answered from the check, a read waits for the store's registered read port.
// busy drops in the cycle the result is shown, so the next beat can start there. The byte
// store needs no clearing after reset. Slot id registers are written through cfg_we,
// cfg_index and cfg_wdata, by the user only while busy is low; the block does not enforce it.
module can_id_demux_ring_buffers
  import cidr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_wdata,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_action,
  input  logic [ID_W-1:0]      in_frame_id,
  input  logic [CNT_W-1:0]     in_byte_count,
  input  logic [BYTE_W-1:0]    in_byte0,
  input  logic [BYTE_W-1:0]    in_byte1,
  input  logic [BYTE_W-1:0]    in_byte2,
  input  logic [BYTE_W-1:0]    in_byte3,
  input  logic [BYTE_W-1:0]    in_byte4,
  input  logic [BYTE_W-1:0]    in_byte5,
  input  logic [BYTE_W-1:0]    in_byte6,
  input  logic [BYTE_W-1:0]    in_byte7,
  input  logic [SLOT_W-1:0]    in_read_slot,
  // result channel, one cycle strobe
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic [SLOT_W-1:0]    out_hit_slot
);

  cidr_cmd_t         cmd;
  cidr_stat_t        stat;
  logic [BYTE_W-1:0] in_bytes [MAX_BYTES];

  // frame bytes gathered into one array for the write mux
  assign in_bytes[0] = in_byte0;
  assign in_bytes[1] = in_byte1;
  assign in_bytes[2] = in_byte2;
  assign in_bytes[3] = in_byte3;
  assign in_bytes[4] = in_byte4;
  assign in_bytes[5] = in_byte5;
  assign in_bytes[6] = in_byte6;
  assign in_bytes[7] = in_byte7;

  // sequencer: decides refuse / write / read from datapath status
  cidr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .res_strobe (out_strobe)
  );

  // datapath: id compare, ring pointers, byte store, result registers
  cidr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_frame_id   (in_frame_id),
    .in_byte_count (in_byte_count),
    .in_bytes      (in_bytes),
    .in_read_slot  (in_read_slot),
    .cmd           (cmd),
    .stat          (stat),
    .res_status    (out_status),
    .res_byte      (out_read_byte),
    .res_slot      (out_hit_slot)
  );

endmodule

### rtl/cidr_ram.sv
// cidr_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cidr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/cidr_ctrl.sv
// cidr_ctrl: sequencing state machine for frame receive and byte read
// depends on cidr_pkg
`timescale 1ns / 1ps

module cidr_ctrl
  import cidr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  cidr_stat_t stat,
  output cidr_cmd_t  cmd,
  output logic       busy,
  output logic       res_strobe
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_RD_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_read) begin
          if (stat.empty) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_EMPTY;
            state_nxt      = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RD_DATA;
          end
        end else begin
          priority if (!stat.matched) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_UNKNOWN;
            state_nxt      = S_IDLE;
          end else if (!stat.fits) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_IDLE;
          end else if (stat.zero_count) begin
            cmd.res_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_byte = 1'b1;
        if (stat.last_byte) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD_DATA: begin
        cmd.rd_take  = 1'b1;
        cmd.res_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.res_load;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign res_strobe = strobe_r;

endmodule

### rtl/cidr_dp.sv
// cidr_dp: id match, ring pointers, byte store and result registers
// depends on cidr_pkg and cidr_ram
`timescale 1ns / 1ps

module cidr_dp
  import cidr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_wdata,
  input  logic                 in_action,
  input  logic [ID_W-1:0]      in_frame_id,
  input  logic [CNT_W-1:0]     in_byte_count,
  input  logic [BYTE_W-1:0]    in_bytes [MAX_BYTES],
  input  logic [SLOT_W-1:0]    in_read_slot,
  input  cidr_cmd_t            cmd,
  output cidr_stat_t           stat,
  output logic [1:0]           res_status,
  output logic [BYTE_W-1:0]    res_byte,
  output logic [SLOT_W-1:0]    res_slot
);

  logic [ID_W-1:0]   slot_id_r [REG_COUNT];
  logic [PTR_W-1:0]  wp_r [SLOT_COUNT];
  logic [PTR_W-1:0]  rp_r [SLOT_COUNT];
  logic [BYTE_W-1:0] bytes_r [MAX_BYTES];
  logic              action_r;
  logic              matched_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  n_r;
  logic [BIDX_W-1:0] cnt_r;
  logic [1:0]        status_r;
  logic [BYTE_W-1:0] byte_r;
  logic [SLOT_W-1:0] hit_r;

  logic              match0, match1;
  logic [PTR_W-1:0]  wp_cur, rp_cur;
  logic [PTR_W:0]    used, room;
  logic [BYTE_W-1:0] ram_rdata;

  // lowest matching slot wins
  assign match0 = (in_frame_id == slot_id_r[0]);
  assign match1 = (in_frame_id == slot_id_r[1]);

  assign wp_cur = wp_r[slot_r];
  assign rp_cur = rp_r[slot_r];

  always_comb begin
    if (wp_cur >= rp_cur) used = {1'b0, wp_cur} - {1'b0, rp_cur};
    else used = (PTR_W+1)'(RING_DEPTH) - {1'b0, rp_cur} + {1'b0, wp_cur};
    room = (PTR_W+1)'(RING_DEPTH - 1) - used;
  end

  always_comb begin
    stat            = '0;
    stat.is_read    = action_r;
    stat.matched    = matched_r;
    stat.fits       = ((PTR_W+1)'(n_r) <= room);
    stat.zero_count = (n_r == '0);
    stat.empty      = (rp_cur == wp_cur);
    stat.last_byte  = ({1'b0, cnt_r} + CNT_W'(1) == n_r);
  end

  cidr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_byte),
    .waddr (ring_addr(slot_r, wp_cur)),
    .wdata (bytes_r[cnt_r]),
    .re    (cmd.rd_issue),
    .raddr (ring_addr(slot_r, rp_cur)),
    .rdata (ram_rdata)
  );

  // control state: config, pointers, action and match flags, byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) slot_id_r[i] <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
      action_r  <= 1'b0;
      matched_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOT0_ID: slot_id_r[0] <= cfg_wdata;
          REG_SLOT1_ID: slot_id_r[1] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        action_r  <= in_action;
        matched_r <= match0 || match1;
        cnt_r     <= '0;
      end
      if (cmd.wr_byte) begin
        wp_r[slot_r] <= ptr_inc(wp_cur);
        cnt_r        <= cnt_r + BIDX_W'(1);
      end
      if (cmd.rd_take) begin
        rp_r[slot_r] <= ptr_inc(rp_cur);
      end
    end
  end

  // payload and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bytes_r <= in_bytes;
      n_r     <= (in_byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : in_byte_count;
      if (in_action) slot_r <= in_read_slot;
      else slot_r <= match0 ? SLOT_W'(0) : SLOT_W'(1);
    end
    if (cmd.res_load) begin
      status_r <= cmd.res_status;
      byte_r   <= cmd.rd_take ? ram_rdata : '0;
      hit_r    <= (cmd.res_status == ST_UNKNOWN) ? '0 : slot_r;
    end
  end

  assign res_status = status_r;
  assign res_byte   = byte_r;
  assign res_slot   = hit_r;

endmodule

### rtl/cidr_checker.sv
// cidr_checker: port level assertions for can_id_demux_ring_buffers, with its bind
// depends on cidr_pkg
`timescale 1ns / 1ps

module cidr_checker
  import cidr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [1:0]        out_status,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic [SLOT_W-1:0] out_hit_slot
);

  // every result closes a beat that was in flight
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a beat in flight");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("beat accepted but block not busy");

  // one beat at a time, so results never come in adjacent cycles
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results in adjacent cycles");

  // only an ok result carries a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_read_byte == '0))
    else $error("byte returned on a refused beat");

  // unknown id reports slot zero
  a_unknown_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_UNKNOWN) |-> (out_hit_slot == '0))
    else $error("unknown id with nonzero slot");

endmodule

bind can_id_demux_ring_buffers cidr_checker u_cidr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_read_byte (out_read_byte),
  .out_hit_slot  (out_hit_slot)
);
